// ===== rtl/coal_pkg.sv =====
`default_nettype none

package coal_pkg;

	// Event types on the input side
	localparam logic [15:0] MODE_SYNC = 16'h0000;
	localparam logic [15:0] MODE_KEY  = 16'h0001;
	localparam logic [15:0] MODE_REL  = 16'h0002;
	localparam logic [15:0] MODE_ABS  = 16'h0003;

	// Axis codes
	localparam logic [15:0] CODE_X     = 16'h0000;
	localparam logic [15:0] CODE_Y     = 16'h0001;
	localparam logic [15:0] CODE_WHEEL = 16'h0008;

	// Gear keys get a fake press ahead of their release
	localparam logic [15:0] KEY_GEAR_DOWN = 16'h0150;
	localparam logic [15:0] KEY_GEAR_UP   = 16'h0151;

	// Result kinds
	localparam logic [2:0] KIND_REL     = 3'd0;
	localparam logic [2:0] KIND_ABS     = 3'd1;
	localparam logic [2:0] KIND_WHEEL   = 3'd2;
	localparam logic [2:0] KIND_PRESS   = 3'd3;
	localparam logic [2:0] KIND_RELEASE = 3'd4;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ABS_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ABS_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_FULL_SCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_FULL_SCALE = 2'd3;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Quotient bits produced by the serial divider (size is 16 bits wide)
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		OP_SYNC,
		OP_KEY,
		OP_REL_X,
		OP_REL_Y,
		OP_WHEEL,
		OP_ABS_X,
		OP_ABS_Y,
		OP_NONE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [15:0] code;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] key;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] size;
		logic [31:0] raw;
		logic [31:0] full;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] value;
	} div_rsp_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WAIT,
		BK_EMIT
	} back_state_t;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_MUL,
		DIV_CHK,
		DIV_RUN,
		DIV_FIN
	} div_state_t;

endpackage

`default_nettype wire

// ===== rtl/coal_front.sv =====
`default_nettype none

module coal_front #(
	parameter int unsigned DEPTH = coal_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [15:0]    mode,
	input  logic [15:0]    event_code,
	input  logic [31:0]    event_value,
	output coal_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);
	import coal_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_op_t          op;
	logic             push;
	logic             pop;

	// Classify the incoming transaction
	always_comb begin
		unique case (mode)
			MODE_SYNC: op = OP_SYNC;
			MODE_KEY:  op = OP_KEY;
			MODE_REL: begin
				if (event_code == CODE_X)
					op = OP_REL_X;
				else if (event_code == CODE_Y)
					op = OP_REL_Y;
				else if (event_code == CODE_WHEEL)
					op = OP_WHEEL;
				else
					op = OP_NONE;
			end
			MODE_ABS: begin
				if (event_code == CODE_X)
					op = OP_ABS_X;
				else if (event_code == CODE_Y)
					op = OP_ABS_Y;
				else
					op = OP_NONE;
			end
			default: op = OP_NONE;
		endcase
	end

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	// Drop events that change nothing; queue the rest
	assign push = in_valid && in_ready && (op != OP_NONE);
	assign pop  = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= '{op: op, code: event_code, value: event_value};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/coal_div.sv =====
`default_nettype none

module coal_div (
	input  logic               clk,
	input  logic               arst_n,
	input  coal_pkg::div_req_t req,
	output coal_pkg::div_rsp_t rsp
);
	import coal_pkg::*;

	div_state_t           state_q;
	div_state_t           state_d;
	logic [15:0]          size_q;
	logic [31:0]          raw_q;
	logic [31:0]          full_q;
	logic [47:0]          prod_q;
	logic [31:0]          rem_q;
	logic [DIV_STEPS-1:0] lo_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [15:0]          value_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 ge;
	logic                 over;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, lo_q[DIV_STEPS-1]};
	assign diff  = trial - {1'b0, full_q};
	assign ge    = (trial >= {1'b0, full_q});

	// Quotient of 2^16 or more always saturates; covers a zero divisor too
	assign over = (prod_q[47:16] >= full_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: if (req.valid) state_d = DIV_MUL;
			DIV_MUL:  state_d = DIV_CHK;
			DIV_CHK:  state_d = over ? DIV_IDLE : DIV_RUN;
			DIV_RUN:  if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = DIV_FIN;
			DIV_FIN:  state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == DIV_CHK) && over) || (state_q == DIV_FIN);
		end
	end

	// Operand capture, product, and the serial quotient
	always_ff @(posedge clk) begin
		unique case (state_q)
			DIV_IDLE: begin
				if (req.valid) begin
					size_q <= req.size;
					raw_q  <= req.raw;
					full_q <= req.full;
				end
			end
			DIV_MUL: prod_q <= size_q * raw_q;
			DIV_CHK: begin
				rem_q   <= prod_q[47:16];
				lo_q    <= prod_q[DIV_STEPS-1:0];
				quo_q   <= '0;
				cnt_q   <= '0;
				value_q <= size_q;
			end
			DIV_RUN: begin
				rem_q <= ge ? diff[31:0] : trial[31:0];
				lo_q  <= {lo_q[DIV_STEPS-2:0], 1'b0};
				quo_q <= {quo_q[DIV_STEPS-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			DIV_FIN: value_q <= (quo_q > size_q) ? size_q : quo_q;
			default: ;
		endcase
	end

	assign rsp = '{done: done_q, value: value_q};

endmodule

`default_nettype wire

// ===== rtl/coal_back.sv =====
`default_nettype none

module coal_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [coal_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	input  coal_pkg::cmd_t                    cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	output coal_pkg::div_req_t                div_req,
	input  coal_pkg::div_rsp_t                div_rsp,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        kind,
	output logic signed [31:0]                coord_x,
	output logic signed [31:0]                coord_y,
	output logic [15:0]                       key_code,
	output logic                              last
);
	import coal_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic [15:0] abs_width_q;
	logic [15:0] abs_height_q;
	logic [31:0] x_full_scale_q;
	logic [31:0] y_full_scale_q;

	logic [31:0] rel_x_q;
	logic [31:0] rel_y_q;
	logic [31:0] abs_x_q;
	logic [31:0] abs_y_q;
	logic        prev_key_valid_q;
	logic [15:0] prev_key_code_q;
	logic [31:0] prev_key_value_q;

	logic        axis_y_q;
	res_t        res0_q;
	res_t        res1_q;
	logic [1:0]  rem_cnt_q;
	logic        out_valid_q;
	res_t        out_res_q;
	logic        out_last_q;

	logic        pop;
	logic        out_load;
	res_t        r0;
	res_t        r1;
	logic [1:0]  nres;
	logic        rel_pend;
	logic        abs_pend;
	logic        key_dup;
	logic        gear;
	res_t        rel_r;
	res_t        abs_r;
	res_t        press_r;
	res_t        release_r;

	assign pop      = cmd_valid && cmd_ready;
	assign out_load = !out_valid_q || out_ready;

	// Build the results a popped command causes
	always_comb begin
		rel_pend  = (rel_x_q != '0) || (rel_y_q != '0);
		abs_pend  = !abs_x_q[31] || !abs_y_q[31];
		key_dup   = prev_key_valid_q && (prev_key_code_q == cmd.code) &&
			(prev_key_value_q == cmd.value);
		gear      = ((cmd.code == KEY_GEAR_UP) || (cmd.code == KEY_GEAR_DOWN)) &&
			(cmd.value == '0);
		rel_r     = '{kind: KIND_REL, x: rel_x_q, y: rel_y_q, key: '0};
		abs_r     = '{kind: KIND_ABS, x: abs_x_q, y: abs_y_q, key: '0};
		press_r   = '{kind: KIND_PRESS, x: '0, y: '0, key: cmd.code};
		release_r = '{kind: KIND_RELEASE, x: '0, y: '0, key: cmd.code};
		r0   = rel_r;
		r1   = abs_r;
		nres = 2'd0;
		unique case (cmd.op)
			OP_SYNC: begin
				if (rel_pend) begin
					r0   = rel_r;
					r1   = abs_r;
					nres = abs_pend ? 2'd2 : 2'd1;
				end else begin
					r0   = abs_r;
					nres = abs_pend ? 2'd1 : 2'd0;
				end
			end
			OP_WHEEL: begin
				r0   = '{kind: KIND_WHEEL, x: '0, y: cmd.value, key: '0};
				nres = 2'd1;
			end
			OP_KEY: begin
				priority if (key_dup) begin
					nres = 2'd0;
				end else if (gear) begin
					r0   = press_r;
					r1   = release_r;
					nres = 2'd2;
				end else if (cmd.value == 32'd0) begin
					r0   = release_r;
					nres = 2'd1;
				end else if (cmd.value == 32'd1) begin
					r0   = press_r;
					nres = 2'd1;
				end else begin
					nres = 2'd0;
				end
			end
			default: nres = 2'd0;
		endcase
	end

	// Hand absolute values to the divider
	always_comb begin
		div_req.valid = pop && ((cmd.op == OP_ABS_X) || (cmd.op == OP_ABS_Y));
		div_req.raw   = cmd.value;
		div_req.size  = (cmd.op == OP_ABS_Y) ? abs_height_q : abs_width_q;
		div_req.full  = (cmd.op == OP_ABS_Y) ? y_full_scale_q : x_full_scale_q;
	end

	// Next state
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if ((cmd.op == OP_ABS_X) || (cmd.op == OP_ABS_Y))
						state_d = BK_WAIT;
					else if (nres != 2'd0)
						state_d = BK_EMIT;
				end
			end
			BK_WAIT: if (div_rsp.done) state_d = BK_IDLE;
			BK_EMIT: if (out_load && (rem_cnt_q == 2'd1)) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration, held event state and the output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_width_q      <= 16'hFFFF;
			abs_height_q     <= 16'hFFFF;
			x_full_scale_q   <= 32'd65535;
			y_full_scale_q   <= 32'd65535;
			rel_x_q          <= '0;
			rel_y_q          <= '0;
			abs_x_q          <= '1;
			abs_y_q          <= '1;
			prev_key_valid_q <= 1'b0;
			prev_key_code_q  <= '0;
			prev_key_value_q <= '0;
			rem_cnt_q        <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ABS_WIDTH:    abs_width_q    <= cfg_data[15:0];
					CFG_ABS_HEIGHT:   abs_height_q   <= cfg_data[15:0];
					CFG_X_FULL_SCALE: x_full_scale_q <= cfg_data;
					CFG_Y_FULL_SCALE: y_full_scale_q <= cfg_data;
				endcase
			end

			if (pop) begin
				rem_cnt_q <= nres;
				unique case (cmd.op)
					OP_SYNC: begin
						rel_x_q <= '0;
						rel_y_q <= '0;
						if (abs_pend) begin
							abs_x_q <= '1;
							abs_y_q <= '1;
						end
					end
					OP_REL_X: rel_x_q <= cmd.value;
					OP_REL_Y: rel_y_q <= cmd.value;
					OP_KEY: begin
						if (!key_dup) begin
							prev_key_valid_q <= 1'b1;
							prev_key_code_q  <= cmd.code;
							prev_key_value_q <= cmd.value;
						end
					end
					default: ;
				endcase
			end

			// Store the scaled axis and raise the other one to at least zero
			if ((state_q == BK_WAIT) && div_rsp.done) begin
				if (axis_y_q) begin
					abs_y_q <= {16'd0, div_rsp.value};
					if (abs_x_q[31])
						abs_x_q <= '0;
				end else begin
					abs_x_q <= {16'd0, div_rsp.value};
					if (abs_y_q[31])
						abs_y_q <= '0;
				end
			end

			if ((state_q == BK_EMIT) && out_load) begin
				rem_cnt_q   <= rem_cnt_q - 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result slots and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res0_q   <= r0;
			res1_q   <= r1;
			axis_y_q <= (cmd.op == OP_ABS_Y);
		end
		if ((state_q == BK_EMIT) && out_load) begin
			out_res_q  <= res0_q;
			out_last_q <= (rem_cnt_q == 2'd1);
			res0_q     <= res1_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_res_q.kind;
	assign coord_x   = out_res_q.x;
	assign coord_y   = out_res_q.y;
	assign key_code  = out_res_q.key;
	assign last      = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/input_event_coalescer.sv =====
`default_nettype none

// Input event coalescer: takes (mode, event_code, event_value) events and
// delivers translated pointer, wheel and key results, at most two per event,
// with last marking the final one. A front end classifies each event and
// queues it (QUEUE_DEPTH entries); unknown events are accepted and dropped
// there. The back end runs one queued command at a time: relative, sync, wheel
// and key commands are decoded when popped, and each result is then delivered
// through the output register. An absolute X or Y event is scaled by a multiply
// and a 16-step radix-2 divider, which the back end waits for. Results sit in an
// output register, so the front keeps filling the queue while a result waits.
// Configuration writes are taken in any cycle but are meant for idle periods.
module input_event_coalescer #(
	parameter int unsigned QUEUE_DEPTH = coal_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [coal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    mode,
	input  logic [15:0]                    event_code,
	input  logic [31:0]                    event_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     kind,
	output logic signed [31:0]             coord_x,
	output logic signed [31:0]             coord_y,
	output logic [15:0]                    key_code,
	output logic                           last
);
	import coal_pkg::*;

	cmd_t     cmd;
	logic     cmd_valid;
	logic     cmd_ready;
	div_req_t div_req;
	div_rsp_t div_rsp;

	coal_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.event_code (event_code),
		.event_value(event_value),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready)
	);

	coal_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	coal_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.key_code (key_code),
		.last     (last)
	);

`ifndef SYNTHESIS
	// Absolute results always carry both axes set
	a_abs_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_ABS)) |-> (!coord_x[31] && !coord_y[31]))
		else $error("absolute result with an unset axis");

	// Relative motion is only reported when something moved
	a_rel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_REL)) |-> ((coord_x != 0) || (coord_y != 0)))
		else $error("relative result with no motion");

	// Every absolute command starts the divider
	a_abs_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && ((cmd.op == OP_ABS_X) || (cmd.op == OP_ABS_Y)))
		|-> div_req.valid)
		else $error("absolute command popped without a divide");

	// The back end holds the queue while a divide is outstanding
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> !cmd_ready)
		else $error("divide finished while the back end was not waiting");
`endif

endmodule

`default_nettype wire
